/* src/fifo_with_keyed_removal_core_macros.svh */
// assertion macros shared by the keyed-removal queue rtl
`ifndef FIFO_WITH_KEYED_REMOVAL_CORE_MACROS_SVH
`define FIFO_WITH_KEYED_REMOVAL_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FWKR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fwkr same-cycle check failed");
// next-cycle implication
`define FWKR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fwkr next-cycle check failed");
`else
`define FWKR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FWKR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/fwkr_pkg.sv */
// shared types and codes for the keyed-removal queue
`default_nettype none

package fwkr_pkg;

    localparam int ID_W  = 16;
    localparam int OCC_W = 4;

    // request codes
    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_LEAVE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_ADMITTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // control broadcast to every cell
    typedef struct packed {
        logic            en;
        logic            leave;
        logic [ID_W-1:0] key;
        logic [ID_W-1:0] new_id;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* src/fwkr_cell.sv */
// one queue slot: key compare, match chain and shift-down
`default_nettype none

module fwkr_cell import fwkr_pkg::*; (
    input  wire logic            i_clk,
    input  wire t_cell_ctl       i_ctl,
    input  wire logic            i_occupied,
    input  wire logic            i_tail,
    input  wire logic            i_prior_hit,
    input  wire logic [ID_W-1:0] i_up_data,
    output logic                 o_hit,
    output logic [ID_W-1:0]      o_data
);

    logic [ID_W-1:0] r_data;
    logic [ID_W-1:0] n_data;
    logic            w_match;

    assign w_match = i_occupied && (r_data == i_ctl.key);
    // set when this slot or any older slot below it holds a match
    assign o_hit   = i_prior_hit | w_match;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.en) begin
            if (i_ctl.leave) begin
                if (o_hit) begin
                    n_data = i_up_data;
                end
            end else if (i_tail) begin
                n_data = i_ctl.new_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

/* src/fifo_with_keyed_removal_core.sv */
// ordered identifier queue with keyed removal, one result per request
// the result of an accepted request is valid in the output register in the cycle after accept
// throughput: one request per cycle while the result channel is not stalled; the clock
//   period is set by the key compare in every cell and the match flag rippling along the row of DEPTH cells
// reset: synchronous active low; queue empties, next identifier returns to 1,
//   no result pending; slot contents are left as they were
`default_nettype none

`include "fifo_with_keyed_removal_core_macros.svh"

module fifo_with_keyed_removal_core import fwkr_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request channel
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_req_type,
    input  wire logic [ID_W-1:0]  i_key_id,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [1:0]            o_status,
    output logic [ID_W-1:0]       o_item_id,
    output logic [OCC_W-1:0]      o_occupancy
);

    // count must hold DEPTH itself
    localparam int CW = $clog2(DEPTH + 1);

    // control state
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [ID_W-1:0]  r_next_id;
    logic [ID_W-1:0]  n_next_id;
    logic             r_out_valid;
    logic             n_out_valid;

    // result register
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic [ID_W-1:0]  r_item_id;
    logic [ID_W-1:0]  n_item_id;
    logic [OCC_W-1:0] r_occupancy;
    logic [OCC_W-1:0] n_occupancy;

    // cell row wiring
    t_cell_ctl        w_ctl;
    logic [DEPTH:0]   w_hit;
    logic [ID_W-1:0]  w_data [DEPTH+1];
    logic             w_accept;
    logic             w_full;
    logic             w_found;

    // the output register frees up as soon as its result is taken
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_found = w_hit[DEPTH];

    // broadcast to every cell
    always_comb begin
        w_ctl.en     = w_accept;
        w_ctl.leave  = (i_req_type == REQ_LEAVE);
        w_ctl.key    = i_key_id;
        w_ctl.new_id = r_next_id;
    end

    // no match before the first slot, nothing above the last
    assign w_hit[0]      = 1'b0;
    assign w_data[DEPTH] = '0;

    // row of cells, slot 0 is the oldest entry
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fwkr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (CW'(g) < r_count),
            .i_tail      (CW'(g) == r_count),
            .i_prior_hit (w_hit[g]),
            .i_up_data   (w_data[g+1]),
            .o_hit       (w_hit[g+1]),
            .o_data      (w_data[g])
        );
    end

    // result and bookkeeping for the accepted request
    always_comb begin
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_status    = r_status;
        n_item_id   = r_item_id;
        n_occupancy = r_occupancy;
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_accept) begin
            n_out_valid = 1'b1;
            if (i_req_type == REQ_ARRIVE) begin
                if (w_full) begin
                    // refused: nothing moves, sequence does not advance
                    n_status  = ST_FULL;
                    n_item_id = '0;
                end else begin
                    n_status  = ST_ADMITTED;
                    n_item_id = r_next_id;
                    n_count   = r_count + CW'(1);
                    n_next_id = r_next_id + ID_W'(1);
                end
            end else begin
                if (w_found) begin
                    n_status  = ST_REMOVED;
                    n_item_id = i_key_id;
                    n_count   = r_count - CW'(1);
                end else begin
                    // also covers an empty queue
                    n_status  = ST_NOTFOUND;
                    n_item_id = '0;
                end
            end
            n_occupancy = OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_next_id   <= ID_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_item_id   <= n_item_id;
        r_occupancy <= n_occupancy;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_item_id   = r_item_id;
    assign o_occupancy = r_occupancy;

    // occupancy never exceeds the row length
    `FWKR_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    // an admitted arrival grows the queue by one and issues the old sequence number
    `FWKR_ASSERT_NEXT(a_admit_grows, i_clk, i_rst_n, w_accept && (i_req_type == REQ_ARRIVE) && !w_full, (r_count == $past(r_count) + CW'(1)) && (o_item_id == $past(r_next_id)))
    // a found key is reported removed and the queue shrinks by one
    `FWKR_ASSERT_NEXT(a_leave_hit, i_clk, i_rst_n, w_accept && (i_req_type == REQ_LEAVE) && w_found, (o_status == ST_REMOVED) && (r_count == $past(r_count) - CW'(1)))
    // sequence number only moves on an admitted arrival
    `FWKR_ASSERT_NEXT(a_seq_hold, i_clk, i_rst_n, !(w_accept && (i_req_type == REQ_ARRIVE) && !w_full), $stable(r_next_id))

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the keyed-removal identifier queue
module testbench;
    import fwkr_pkg::*;

    localparam int DEPTH       = 8;
    localparam int IDLE_LIMIT  = 1000;  // cycles with no handshake before giving up
    localparam int BACKLOG_MAX = 4;
    localparam int PRESSURE_AT = 200;   // results seen before the long receiver hold
    localparam int PRESSURE_LEN = 60;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] key;
    } t_request;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  item_id;
        logic [OCC_W-1:0] occupancy;
    } t_outcome;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_req_type = REQ_ARRIVE;
    logic [ID_W-1:0]  i_key_id = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [1:0]       o_status;
    logic [ID_W-1:0]  o_item_id;
    logic [OCC_W-1:0] o_occupancy;

    fifo_with_keyed_removal_core #(.DEPTH(DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_key_id    (i_key_id),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_item_id   (o_item_id),
        .o_occupancy (o_occupancy)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // shadow of the queue: held identifiers oldest first, and the next sequence number
    logic [ID_W-1:0] held_ids[$];
    logic [ID_W-1:0] model_next_id = 16'd1;
    t_outcome        expected_outcomes[$];
    t_request        request_backlog[$];

    int requests_queued   = 0;
    int requests_accepted = 0;
    int results_seen      = 0;
    int mismatch_count    = 0;
    int sender_idle_pct   = 30;
    int receiver_idle_pct = 30;

    // work out the result of one accepted request and update the shadow queue
    task automatic predict_outcome(input t_request r);
        t_outcome o;
        int       hit;
        hit = -1;
        o = '0;
        if (r.kind == REQ_ARRIVE) begin
            if (held_ids.size() >= DEPTH) begin
                o.status = ST_FULL;
            end else begin
                held_ids.push_back(model_next_id);
                o.status  = ST_ADMITTED;
                o.item_id = model_next_id;
                model_next_id = model_next_id + ID_W'(1);
            end
        end else begin
            // oldest match wins when identifiers repeat after the wrap
            foreach (held_ids[i])
                if (hit < 0 && held_ids[i] == r.key)
                    hit = i;
            if (hit < 0) begin
                o.status = ST_NOTFOUND;
            end else begin
                held_ids.delete(hit);
                o.status  = ST_REMOVED;
                o.item_id = r.key;
            end
        end
        o.occupancy = OCC_W'(held_ids.size());
        expected_outcomes.push_back(o);
    endtask

    // idle length: mostly none, otherwise short, now and then long
    function automatic int draw_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic int draw_idle_pct();
        return ($urandom_range(3) == 0) ? 0 : 30;
    endfunction

    // request driver
    t_request current_req;
    logic     offer;
    int       send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            offer = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_outcome(current_req);
                requests_accepted++;
                if (requests_accepted % 100 == 0)
                    sender_idle_pct = draw_idle_pct();
                offer = 1'b0;
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_backlog.size() > 0) begin
                    current_req = request_backlog.pop_front();
                    i_req_type <= current_req.kind;
                    i_key_id   <= current_req.key;
                    offer = 1'b1;
                    send_gap = draw_gap(sender_idle_pct);
                end
            end
            i_in_valid <= offer;
        end
    end

    // result monitor and receiver stalls
    t_outcome got_outcome;
    t_outcome want_outcome;
    logic     take_next;
    int       stall_left = 0;
    int       hold_left  = 0;
    bit       pressure_done = 1'b0;

    task automatic compare_field(input string field, input logic [ID_W-1:0] want,
                                 input logic [ID_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_outcome = '{o_status, o_item_id, o_occupancy};
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: result with none expected, actual status %0d item %0d occ %0d",
                             $time, o_status, o_item_id, o_occupancy);
                    mismatch_count++;
                end else begin
                    want_outcome = expected_outcomes.pop_front();
                    compare_field("status", ID_W'(want_outcome.status),
                                  ID_W'(got_outcome.status));
                    compare_field("item_id", want_outcome.item_id, got_outcome.item_id);
                    compare_field("occupancy", ID_W'(want_outcome.occupancy),
                                  ID_W'(got_outcome.occupancy));
                end
                results_seen++;
                if (results_seen % 100 == 0)
                    receiver_idle_pct = draw_idle_pct();
            end
            // one long hold so that the output backs up and the request side stalls
            if (hold_left > 0) begin
                hold_left--;
                take_next = 1'b0;
            end else if (!pressure_done && results_seen >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left = PRESSURE_LEN;
                take_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                take_next = 1'b0;
            end else begin
                stall_left = draw_gap(receiver_idle_pct);
                take_next = (stall_left == 0);
            end
            i_out_ready <= take_next;
        end
    end

    // watchdog on cycles with no handshake on either side
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // stimulus: fed a few requests ahead of the driver
    task automatic queue_request(input logic kind, input logic [ID_W-1:0] key);
        while (request_backlog.size() >= BACKLOG_MAX)
            @(negedge i_clk);
        request_backlog.push_back('{kind, key});
        requests_queued++;
    endtask

    task automatic wait_until_settled();
        while (requests_accepted != requests_queued)
            @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [ID_W-1:0] pick;
        int              fill_pct;

        // leave on an empty queue, both key extremes
        queue_request(REQ_LEAVE, 16'h0000);
        queue_request(REQ_LEAVE, 16'hFFFF);
        // fill to the top; key is don't-care on arrive
        for (int n = 0; n < DEPTH; n++)
            queue_request(REQ_ARRIVE, (n % 2 == 0) ? 16'hFFFF : 16'h0000);
        // arrive when full is refused
        queue_request(REQ_ARRIVE, 16'h1234);
        // middle, repeat of a removed one, oldest, youngest
        queue_request(REQ_LEAVE, 16'd4);
        queue_request(REQ_LEAVE, 16'd4);
        queue_request(REQ_LEAVE, 16'd1);
        queue_request(REQ_LEAVE, 16'd8);
        queue_request(REQ_ARRIVE, 16'h5A5A);
        queue_request(REQ_LEAVE, 16'hFFFF);
        queue_request(REQ_LEAVE, 16'h0000);
        // drain what is left
        queue_request(REQ_LEAVE, 16'd2);
        queue_request(REQ_LEAVE, 16'd3);
        queue_request(REQ_LEAVE, 16'd5);
        queue_request(REQ_LEAVE, 16'd6);
        queue_request(REQ_LEAVE, 16'd7);
        queue_request(REQ_LEAVE, 16'd9);

        // random traffic in phases that lean towards filling, draining or neither
        fill_pct = 50;
        for (int n = 0; n < 630; n++) begin
            if (n % 40 == 0)
                case ($urandom_range(2))
                    0: fill_pct = 85;
                    1: fill_pct = 20;
                    default: fill_pct = 50;
                endcase
            if ($urandom_range(99) < fill_pct) begin
                queue_request(REQ_ARRIVE, 16'($urandom));
            end else begin
                if (held_ids.size() > 0 && $urandom_range(99) < 75)
                    pick = held_ids[$urandom_range(held_ids.size() - 1)];
                else if ($urandom_range(19) == 0)
                    pick = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                else
                    pick = 16'($urandom);
                queue_request(REQ_LEAVE, pick);
            end
        end

        wait_until_settled();
        while (expected_outcomes.size() > 0)
            @(negedge i_clk);
        // keep the clock running to catch any stray result
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/fwkr_pkg.sv
src/fwkr_cell.sv
src/fifo_with_keyed_removal_core.sv
tb/testbench.sv
